### design/serial_text_window_scroller_core_assert.svh
// Assertion macros for the serial text window scroller core.
// Needs clk and rst in the scope where the macros are used.
`ifndef SERIAL_TEXT_WINDOW_SCROLLER_CORE_ASSERT_SVH
`define SERIAL_TEXT_WINDOW_SCROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/stws_pkg.sv
// Shared types and constants for the serial text window scroller.
// No dependencies.
package stws_pkg;

  // command codes carried in s_tuser
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // number of screen rows to scroll after one byte (0, 1 or 2)
  typedef logic [1:0] scroll_cnt_t;

endpackage

### design/stws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/stws_cursor.sv
// Cursor update for one stored byte: next column, next row and scroll count.
// Depends on stws_pkg.
module stws_cursor #(
  parameter int WIN_COLS = 16,
  parameter int WIN_ROWS = 4,
  localparam int CW = $clog2(WIN_COLS + 1),
  localparam int RW = $clog2(WIN_ROWS)
) (
  input  logic [CW-1:0]             col,
  input  logic [RW-1:0]             row,
  input  logic [7:0]                rx_byte,
  output logic [CW-1:0]             col_next,
  output logic [RW-1:0]             row_next,
  output stws_pkg::scroll_cnt_t     scroll
);
  import stws_pkg::*;

  logic          line_full;
  logic [RW:0]   nl_row;

  assign line_full = (col == CW'(WIN_COLS));
  // newline after a full line skips one extra row
  assign nl_row    = {1'b0, row} + (line_full ? (RW+1)'(2) : (RW+1)'(1));

  always_comb begin
    col_next = col;
    row_next = row;
    scroll   = '0;
    if (rx_byte == NEWLINE_CODE) begin
      col_next = '0;
      if (nl_row >= (RW+1)'(WIN_ROWS)) begin
        row_next = RW'(WIN_ROWS - 1);
        scroll   = (nl_row == (RW+1)'(WIN_ROWS + 1)) ? scroll_cnt_t'(2) : scroll_cnt_t'(1);
      end else begin
        row_next = nl_row[RW-1:0];
      end
    end else if (line_full) begin
      // wrap: move down, or scroll when already on the last row
      col_next = CW'(1);
      if (row == RW'(WIN_ROWS - 1)) begin
        scroll = scroll_cnt_t'(1);
      end else begin
        row_next = row + RW'(1);
      end
    end else begin
      col_next = col + CW'(1);
    end
  end

endmodule

### design/serial_text_window_scroller_core.sv
// Serial text window scroller core: ring buffer of received bytes with a text window tracker.
// Depends on stws_pkg, stws_ram, stws_cursor and serial_text_window_scroller_core_assert.svh.

// Each accepted word either stores a received byte (s_tuser low) or clears the window
// pointers and counters (s_tuser high); every word yields one result word with the view
// start, write position, cursor column and row and the saturating fill count. A clear
// goes straight to the output state. A stored byte is written and the cursor updated; a
// scroll then primes the read port and scans stored characters, at most 2*WIN_COLS, to
// advance the view start. The result is loaded once the output register is free, and the
// next word is accepted only after that. After reset the character memory is zeroed over
// all BUF_DEPTH addresses, and no word is accepted during that pass. A finished result
// waits in the output register while the next word is taken.
module serial_text_window_scroller_core #(
  parameter int BUF_DEPTH = 256,
  parameter int WIN_COLS  = 16,
  parameter int WIN_ROWS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] start_index, [15:8] end_index, [20:16] cursor_col,
                                 // [22:21] cursor_row, [31:23] fill_count
);
  import stws_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int CW = $clog2(WIN_COLS + 1);
  localparam int RW = $clog2(WIN_ROWS);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_WRITE, S_PRIME, S_SCAN, S_OUT
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] write_ptr;
  logic [AW-1:0] view_start;
  logic [FW-1:0] received_total;
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  scroll_cnt_t   scroll_left;
  logic [CW-1:0] scan_cnt;
  logic [7:0]    byte_reg;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  scroll_cnt_t   scroll_req;

  logic [31:0]   start_w;
  logic [31:0]   end_w;
  logic [31:0]   col_w;
  logic [31:0]   row_w;
  logic [31:0]   fill_w;
  logic          row_done;
  logic          out_load;

  function automatic logic [AW-1:0] next_index(input logic [AW-1:0] idx);
    next_index = (idx == AW'(BUF_DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  assign s_tready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_ptr;
    ram_wdata = byte_reg;
    ram_raddr = view_start;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_WRITE: ram_we = 1'b1;
      // read ahead: fetch the character after the current one, which is scanned next
      S_SCAN:  ram_raddr = next_index(view_start);
      default: ;
    endcase
  end

  stws_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stws_cursor #(
    .WIN_COLS (WIN_COLS),
    .WIN_ROWS (WIN_ROWS)
  ) u_cursor (
    .col      (col_pos),
    .row      (row_pos),
    .rx_byte  (byte_reg),
    .col_next (col_next),
    .row_next (row_next),
    .scroll   (scroll_req)
  );

  assign row_done = (ram_rdata == NEWLINE_CODE) || (scan_cnt == CW'(WIN_COLS - 1));

  // load the output register once it is free
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  assign start_w = 32'(view_start);
  assign end_w   = 32'(write_ptr);
  assign col_w   = 32'(col_pos);
  assign row_w   = 32'(row_pos);
  assign fill_w  = 32'(received_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INIT;
      clr_addr       <= '0;
      write_ptr      <= '0;
      view_start     <= '0;
      received_total <= '0;
      col_pos        <= '0;
      row_pos        <= '0;
      scroll_left    <= '0;
      scan_cnt       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (out_load) begin
        m_tdata  <= {fill_w[8:0], row_w[1:0], col_w[4:0], end_w[7:0], start_w[7:0]};
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(BUF_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            byte_reg <= s_tdata;
            if (s_tuser == CMD_CLEAR) begin
              write_ptr      <= '0;
              view_start     <= '0;
              received_total <= '0;
              col_pos        <= '0;
              row_pos        <= '0;
              state          <= S_OUT;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          write_ptr <= next_index(write_ptr);
          if (received_total != FW'(BUF_DEPTH)) begin
            received_total <= received_total + FW'(1);
          end
          col_pos     <= col_next;
          row_pos     <= row_next;
          scroll_left <= scroll_req;
          scan_cnt    <= '0;
          state       <= (scroll_req != '0) ? S_PRIME : S_OUT;
        end
        S_PRIME: state <= S_SCAN;
        S_SCAN: begin
          view_start <= next_index(view_start);
          if (row_done) begin
            scan_cnt    <= '0;
            scroll_left <= scroll_left - scroll_cnt_t'(1);
            if (scroll_left == scroll_cnt_t'(1)) begin
              state <= S_OUT;
            end
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "serial_text_window_scroller_core_assert.svh"

  `STWS_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "accepted word did not leave idle")
  `STWS_ASSERT_NOW(a_scan_rows, state == S_SCAN, scroll_left != '0, "scan running with no rows left")
  `STWS_ASSERT_NOW(a_row_range, state == S_IDLE, row_pos <= RW'(WIN_ROWS - 1), "cursor row past window")
  `STWS_ASSERT_NOW(a_fill_sat, state == S_IDLE, received_total <= FW'(BUF_DEPTH), "fill count overflow")

endmodule

### verif/testbench.sv
// Self-checking testbench for serial_text_window_scroller_core.
// Needs stws_pkg and the core RTL; drives byte and clear words, predicts the window
// pointers and cursor per word and checks every result word in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stws_pkg::*;

  localparam int BUF_DEPTH  = 256;
  localparam int WIN_COLS   = 16;
  localparam int WIN_ROWS   = 4;
  localparam int ITEM_COUNT = 650;
  localparam int QUIET_TAIL = 100;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic       cmd;
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic [8:0] fill_count;
    logic [1:0] cursor_row;
    logic [4:0] cursor_col;
    logic [7:0] end_index;
    logic [7:0] start_index;
  } window_view_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = CMD_STORE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  rx_word_t     pending_words[$];
  window_view_t expected_views[$];

  // shadow of the window state
  logic [7:0]  shadow_text[BUF_DEPTH];
  int unsigned shadow_wr;
  int unsigned shadow_view;
  int unsigned shadow_fill;
  int unsigned shadow_col;
  int unsigned shadow_row;

  int  error_cnt;
  int  results_seen;
  int  clears_taken;
  int  scroll_words;
  bit  fill_saturated;
  bit  word_taken;
  int  cycle_cnt;

  serial_text_window_scroller_core #(
    .BUF_DEPTH(BUF_DEPTH),
    .WIN_COLS (WIN_COLS),
    .WIN_ROWS (WIN_ROWS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // advance the view by whole screen rows; a row ends after WIN_COLS chars or a newline
  function automatic void scroll_view(int unsigned rows);
    for (int r = 0; r < rows; r++) begin
      for (int k = 0; k < WIN_COLS; k++) begin
        logic nl;
        nl = (shadow_text[shadow_view] == NEWLINE_CODE);
        shadow_view = (shadow_view + 1) % BUF_DEPTH;
        if (nl) break;
      end
    end
  endfunction

  function automatic window_view_t advance_window(logic cmd, logic [7:0] b);
    window_view_t v;
    int unsigned  old_view;
    old_view = shadow_view;
    if (cmd == CMD_CLEAR) begin
      shadow_wr   = 0;
      shadow_view = 0;
      shadow_fill = 0;
      shadow_col  = 0;
      shadow_row  = 0;
      clears_taken++;
    end else begin
      shadow_text[shadow_wr] = b;
      if (shadow_fill < BUF_DEPTH) shadow_fill++;
      shadow_wr = (shadow_wr + 1) % BUF_DEPTH;
      if (b == NEWLINE_CODE) begin
        // a newline after an exactly full line skips a row
        shadow_row += (shadow_col == WIN_COLS) ? 2 : 1;
        shadow_col = 0;
        if (shadow_row >= WIN_ROWS) begin
          scroll_view(shadow_row - WIN_ROWS + 1);
          shadow_row = WIN_ROWS - 1;
        end
      end else begin
        if (shadow_col == WIN_COLS) begin
          if (shadow_row == WIN_ROWS - 1) scroll_view(1);
          else shadow_row++;
          shadow_col = 0;
        end
        shadow_col++;
      end
      if (shadow_view != old_view) scroll_words++;
      if (shadow_fill == BUF_DEPTH) fill_saturated = 1'b1;
    end
    v.start_index = shadow_view[7:0];
    v.end_index   = shadow_wr[7:0];
    v.cursor_col  = shadow_col[4:0];
    v.cursor_row  = shadow_row[1:0];
    v.fill_count  = shadow_fill[8:0];
    return v;
  endfunction

  task automatic add_word(logic cmd, logic [7:0] b);
    rx_word_t w;
    w.cmd     = cmd;
    w.rx_byte = b;
    pending_words.push_back(w);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= NEWLINE_CODE) b++;
    return b;
  endfunction

  task automatic build_stimulus();
    int kind;
    int len;
    // full line starting with 00 and FF, then newlines until the window scrolls one row
    add_word(CMD_CLEAR, 8'hFF);
    add_word(CMD_STORE, 8'h00);
    add_word(CMD_STORE, 8'hFF);
    for (int i = 0; i < WIN_COLS - 2; i++) add_word(CMD_STORE, 8'h61 + 8'(i));
    add_word(CMD_STORE, NEWLINE_CODE);
    add_word(CMD_STORE, NEWLINE_CODE);
    add_word(CMD_STORE, NEWLINE_CODE);
    add_word(CMD_STORE, 8'h78);
    add_word(CMD_CLEAR, NEWLINE_CODE);
    add_word(CMD_STORE, NEWLINE_CODE);

    while (pending_words.size() < ITEM_COUNT) begin
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
        add_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        // text line, often exactly one window row wide
        len = ($urandom_range(0, 3) == 0) ? WIN_COLS : $urandom_range(0, 2 * WIN_COLS + 2);
        for (int i = 0; i < len; i++) add_word(CMD_STORE, text_byte());
        if ($urandom_range(0, 4) != 0) add_word(CMD_STORE, NEWLINE_CODE);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0) add_word(CMD_STORE, NEWLINE_CODE);
          else add_word(CMD_STORE, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // sender: hold a word until taken, with random gaps
  int gap_left;
  always @(negedge clk) begin : drive
    rx_word_t w;
    bit       calm;
    calm = (pending_words.size() < QUIET_TAIL) || ((cycle_cnt / 400) % 3 == 2);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !word_taken)) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 5);
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= w.rx_byte;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the input
  int  stall_left;
  int  long_hold_left;
  bit  long_hold_done;
  always @(negedge clk) begin : receive
    bit calm;
    calm = (pending_words.size() < QUIET_TAIL) || ((cycle_cnt / 400) % 3 == 2);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 200) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    window_view_t got;
    window_view_t want;
    if (!rst && s_tvalid && s_tready) begin
      word_taken = 1'b1;
      expected_views.push_back(advance_window(s_tuser, s_tdata));
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (expected_views.size() == 0) begin
        $error("result word with no expectation: %h", m_tdata);
        error_cnt++;
      end else begin
        want = expected_views.pop_front();
        if (got.start_index !== want.start_index) begin
          $error("start_index: expected %0d, got %0d", want.start_index, got.start_index);
          error_cnt++;
        end
        if (got.end_index !== want.end_index) begin
          $error("end_index: expected %0d, got %0d", want.end_index, got.end_index);
          error_cnt++;
        end
        if (got.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
          error_cnt++;
        end
        if (got.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
          error_cnt++;
        end
        if (got.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_views.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < BUF_DEPTH; i++) shadow_text[i] = '0;
    shadow_wr   = 0;
    shadow_view = 0;
    shadow_fill = 0;
    shadow_col  = 0;
    shadow_row  = 0;
    build_stimulus();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_views.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("checked %0d result words: %0d clears, %0d words that scrolled the view",
             results_seen, clears_taken, scroll_words);
    $display("fill count saturation %s, %0d mismatches",
             fill_saturated ? "reached" : "not reached", error_cnt);
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
